### hdl/assert_macros.svh
// Assertion macros for the RTL of the LFU cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/lfu_pkg.sv
// Package of the LFU cache: default sizes, access codes, FSM states and control structs.
package lfu_pkg;

  // Default sizes
  localparam int unsigned ENTRIES_DEF     = 8;
  localparam int unsigned TAG_WIDTH_DEF   = 32;
  localparam int unsigned WORD_WIDTH_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Capacity register
  localparam int unsigned CAP_WIDTH = 4;
  localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 4'd5;

  // Access codes on the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted beat, clear search trackers
    logic scan;    // walk one entry
    logic commit;  // write the table on an insert and load the response register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // last entry is being examined this cycle
    logic out_free;   // response register can take a new beat
  } status_t;

endpackage

### hdl/lfu_if.sv
// Valid/ready channel interfaces of the LFU cache: request, response and configuration.
interface lfu_req_if #(
  parameter int unsigned TAG_WIDTH  = lfu_pkg::TAG_WIDTH_DEF,
  parameter int unsigned WORD_WIDTH = lfu_pkg::WORD_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [TAG_WIDTH-1:0]  key_tag;
  logic [WORD_WIDTH-1:0] data_word;

  modport source (output valid, output mode, output key_tag, output data_word, input ready);
  modport sink   (input valid, input mode, input key_tag, input data_word, output ready);
endinterface

interface lfu_rsp_if #(
  parameter int unsigned TAG_WIDTH   = lfu_pkg::TAG_WIDTH_DEF,
  parameter int unsigned WORD_WIDTH  = lfu_pkg::WORD_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic                   evicted;
  logic [TAG_WIDTH-1:0]   victim_tag;
  logic [COUNT_WIDTH-1:0] victim_uses;
  logic [WORD_WIDTH-1:0]  read_word;

  modport source (output valid, output hit, output evicted, output victim_tag,
                  output victim_uses, output read_word, input ready);
  modport sink   (input valid, input hit, input evicted, input victim_tag,
                  input victim_uses, input read_word, output ready);
endinterface

interface lfu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfu_pkg::CAP_WIDTH-1:0]  capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

### hdl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lfu_ctrl.sv
// Sequencer of the LFU cache: accept a beat, walk the entries, commit and respond.
module lfu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  lfu_pkg::status_t status_i,
  output lfu_pkg::cmd_t    cmd_o
);

  lfu_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = lfu_pkg::ST_SCAN;
      end
      lfu_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = lfu_pkg::ST_FINISH;
      end
      lfu_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = lfu_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      lfu_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      lfu_pkg::ST_FINISH: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### hdl/lfu_dpath.sv
// Datapath of the LFU cache: entry RAM, valid bits, search trackers, commit and response.
`include "assert_macros.svh"

module lfu_dpath #(
  parameter int unsigned ENTRIES     = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_WIDTH   = lfu_pkg::TAG_WIDTH_DEF,
  parameter int unsigned WORD_WIDTH  = lfu_pkg::WORD_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfu_pkg::cmd_t                 cmd_i,
  output lfu_pkg::status_t              status_o,
  input  logic                          mode_i,
  input  logic [TAG_WIDTH-1:0]          key_tag_i,
  input  logic [WORD_WIDTH-1:0]         data_word_i,
  input  logic                          cfg_valid_i,
  input  logic [lfu_pkg::CAP_WIDTH-1:0] cfg_capacity_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [TAG_WIDTH-1:0]          victim_tag_o,
  output logic [COUNT_WIDTH-1:0]        victim_uses_o,
  output logic [WORD_WIDTH-1:0]         read_word_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W = lfu_pkg::CAP_WIDTH;
  localparam int unsigned CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int unsigned MEM_W = TAG_WIDTH + WORD_WIDTH + COUNT_WIDTH;

  // Latched request
  logic                  mode_q;
  logic [TAG_WIDTH-1:0]  key_q;
  logic [WORD_WIDTH-1:0] data_q;

  // Table state
  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   occ_q;
  logic [CAP_W-1:0]   cap_q;

  // Walk
  logic [CNT_W-1:0] scan_cnt_q;
  logic             proc_vld_q;
  logic [IDX_W-1:0] proc_idx_q;

  // Search trackers
  logic                   match_q;
  logic [IDX_W-1:0]       match_idx_q;
  logic [WORD_WIDTH-1:0]  match_word_q;
  logic [COUNT_WIDTH-1:0] match_uses_q;
  logic                   free_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic                   vic_q;
  logic [IDX_W-1:0]       vic_idx_q;
  logic [TAG_WIDTH-1:0]   vic_tag_q;
  logic [COUNT_WIDTH-1:0] vic_uses_q;

  // Response register
  logic                   rsp_vld_q;
  logic                   rsp_hit_q;
  logic                   rsp_evicted_q;
  logic [TAG_WIDTH-1:0]   rsp_vtag_q;
  logic [COUNT_WIDTH-1:0] rsp_vuses_q;
  logic [WORD_WIDTH-1:0]  rsp_rword_q;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [MEM_W-1:0] ram_wdata;
  logic [MEM_W-1:0] ram_rdata;

  lfu_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Entry fields as read back: {tag, word, uses}
  logic [TAG_WIDTH-1:0]   ent_tag;
  logic [WORD_WIDTH-1:0]  ent_word;
  logic [COUNT_WIDTH-1:0] ent_uses;
  logic                   ent_vld;

  assign ent_tag  = ram_rdata[MEM_W-1 -: TAG_WIDTH];
  assign ent_word = ram_rdata[COUNT_WIDTH +: WORD_WIDTH];
  assign ent_uses = ram_rdata[COUNT_WIDTH-1:0];
  assign ent_vld  = valid_q[proc_idx_q];

  // Per-entry evaluation
  logic examine, take_match, take_free, take_vic;

  assign examine    = cmd_i.scan && proc_vld_q;
  assign take_match = examine && ent_vld && (ent_tag == key_q) && !match_q;
  assign take_free  = examine && !ent_vld && !free_q;
  assign take_vic   = examine && ent_vld &&
                      (!vic_q || (ent_uses < vic_uses_q) ||
                       ((ent_uses == vic_uses_q) && (ent_tag < vic_tag_q)));

  // Status toward the controller
  assign status_o.scan_done = (scan_cnt_q == CNT_W'(ENTRIES));
  assign status_o.out_free  = !rsp_vld_q || rsp_ready_i;

  // Effective capacity, clamped to one..ENTRIES
  logic [CMP_W-1:0] cap_ext, ent_lim, eff_cap;
  logic             has_room;

  assign cap_ext  = CMP_W'(cap_q);
  assign ent_lim  = CMP_W'(ENTRIES);
  assign eff_cap  = (cap_q == '0) ? CMP_W'(1) : ((cap_ext > ent_lim) ? ent_lim : cap_ext);
  assign has_room = CMP_W'(occ_q) < eff_cap;

  // Commit decision
  logic                   wr_en, occ_inc, evict;
  logic [IDX_W-1:0]       dst_idx;
  logic [COUNT_WIDTH-1:0] sat_uses;

  assign sat_uses = (match_uses_q == '1) ? match_uses_q : match_uses_q + COUNT_WIDTH'(1);

  always_comb begin
    wr_en     = 1'b0;
    occ_inc   = 1'b0;
    evict     = 1'b0;
    dst_idx   = match_idx_q;
    ram_wdata = {key_q, match_word_q, sat_uses};
    if (mode_q == lfu_pkg::MODE_INSERT) begin
      wr_en = 1'b1;
      if (!match_q) begin
        ram_wdata = {key_q, data_q, COUNT_WIDTH'(1)};
        priority if (has_room && free_q) begin
          dst_idx = free_idx_q;
          occ_inc = 1'b1;
        end else if (vic_q) begin
          dst_idx = vic_idx_q;
          evict   = 1'b1;
        end else begin
          dst_idx = free_q ? free_idx_q : '0;
          occ_inc = 1'b1;
        end
      end
    end
  end

  assign ram_we    = cmd_i.commit && wr_en;
  assign ram_waddr = dst_idx;

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_tag_i;
      data_q <= data_word_i;
    end
  end

  // Walk counter: each address is issued in the cycle before its entry is examined
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
    end else if (cmd_i.load) begin
      scan_cnt_q <= '0;
      proc_vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (scan_cnt_q != CNT_W'(ENTRIES)) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
        proc_vld_q <= 1'b1;
        proc_idx_q <= scan_cnt_q[IDX_W-1:0];
      end else begin
        proc_vld_q <= 1'b0;
      end
    end
  end

  // Tracker flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else if (cmd_i.load) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else begin
      if (take_match) match_q <= 1'b1;
      if (take_free)  free_q  <= 1'b1;
      if (take_vic)   vic_q   <= 1'b1;
    end
  end

  // Tracker payload
  always_ff @(posedge clk_i) begin
    if (take_match) begin
      match_idx_q  <= proc_idx_q;
      match_word_q <= ent_word;
      match_uses_q <= ent_uses;
    end
    if (take_free) begin
      free_idx_q <= proc_idx_q;
    end
    if (take_vic) begin
      vic_idx_q  <= proc_idx_q;
      vic_tag_q  <= ent_tag;
      vic_uses_q <= ent_uses;
    end
  end

  // Valid bits and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (ram_we) begin
      valid_q[dst_idx] <= 1'b1;
      if (occ_inc) occ_q <= occ_q + CNT_W'(1);
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CAPACITY_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // Response beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_vld_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_hit_q     <= match_q;
      rsp_evicted_q <= evict;
      rsp_vtag_q    <= evict ? vic_tag_q : '0;
      rsp_vuses_q   <= evict ? vic_uses_q : '0;
      rsp_rword_q   <= ((mode_q == lfu_pkg::MODE_READ) && match_q) ? match_word_q : '0;
    end
  end

  assign rsp_valid_o   = rsp_vld_q;
  assign hit_o         = rsp_hit_q;
  assign evicted_o     = rsp_evicted_q;
  assign victim_tag_o  = rsp_vtag_q;
  assign victim_uses_o = rsp_vuses_q;
  assign read_word_o   = rsp_rword_q;

  // Checks
  `ASSERT_CLK(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(occ_q), "occupancy out of step with valid bits")
  `ASSERT_CLK(a_rsp_from_commit, clk_i, rst_ni, $rose(rsp_vld_q) |-> $past(cmd_i.commit), "response raised without a commit")
  `ASSERT_NEVER(a_evict_on_hit, clk_i, rst_ni, rsp_vld_q && rsp_evicted_q && rsp_hit_q, "eviction reported on a hit")
  `ASSERT_CLK(a_word_only_on_hit, clk_i, rst_ni, (rsp_vld_q && !rsp_hit_q) |-> (rsp_rword_q == '0), "read word nonzero on a miss")

endmodule

### hdl/lfu_cache_table.sv
// A request is accepted only in ST_IDLE, so a new request is not taken until the last one has
// been committed; the entry RAM is walked one entry per cycle through its single read port,
// then ST_FINISH commits once the response register can take the result.
// The result register decouples the sides: a new request is taken while a result waits.
// Reset clears the valid bits, occupancy and the FSM, and sets capacity to 5; entry RAM
// contents stay as they are and need no clearing pass.
module lfu_cache_table #(
  parameter int unsigned ENTRIES     = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_WIDTH   = lfu_pkg::TAG_WIDTH_DEF,
  parameter int unsigned WORD_WIDTH  = lfu_pkg::WORD_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o,
  lfu_cfg_if.sink   cfg_i
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;
  logic             req_ready;

  // Configuration beats are always taken
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfu_dpath #(
    .ENTRIES     (ENTRIES),
    .TAG_WIDTH   (TAG_WIDTH),
    .WORD_WIDTH  (WORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (req_i.mode),
    .key_tag_i      (req_i.key_tag),
    .data_word_i    (req_i.data_word),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_capacity_i (cfg_i.capacity),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .hit_o          (rsp_o.hit),
    .evicted_o      (rsp_o.evicted),
    .victim_tag_o   (rsp_o.victim_tag),
    .victim_uses_o  (rsp_o.victim_uses),
    .read_word_o    (rsp_o.read_word)
  );

endmodule
